FILE: sv/assert_macros.svh
// Assertion macros for the date-difference RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, switched off while rst is high.
`define DBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal must carry no X or Z once out of reset.
`define DBD_ASSERT_KNOWN(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !$isunknown(sig)) else $error(msg);

`endif

FILE: sv/dbd_pkg.sv
// Types, constants and month table for the date-difference block.
package dbd_pkg;

  localparam int unsigned DATE_W     = 27;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned REST_W     = 14;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned DN_W       = 23;
  localparam int unsigned DIFF_W     = 23;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 24;

  // pipeline depth of one lane, in registers
  localparam int unsigned LANE_DEPTH = 7;

  // v / 10000 as (v * RECIP_10K) >> RECIP_10K_SHIFT, low by at most one
  localparam int unsigned TEN_K           = 10000;
  localparam int unsigned RECIP_10K       = 109951162;
  localparam int unsigned RECIP_10K_SHIFT = 40;

  // x / 100 exact for x below 43690
  localparam int unsigned HUNDRED         = 100;
  localparam int unsigned RECIP_100       = 5243;
  localparam int unsigned RECIP_100_SHIFT = 19;

  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DIFF_LIMIT    = 3660000;

  typedef struct packed {
    logic            ok;
    logic [DN_W-1:0] dn;
  } lane_out_t;

  // days in the months before the given one
  function automatic logic [8:0] days_before_month(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
    logic [8:0] base;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (month > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

FILE: sv/dbd_lane.sv
// One lane: packed YYYYMMDD date to running day number, seven register stages.
module dbd_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dbd_pkg::DATE_W-1:0]    date,
  output dbd_pkg::lane_out_t            result
);

  localparam int unsigned PROD_W = 2 * dbd_pkg::DATE_W;

  // stage 1: reciprocal product
  logic [dbd_pkg::DATE_W-1:0]  v1;
  logic [PROD_W-1:0]           p1;
  // stage 2: year estimate and its multiple of 10000
  logic [dbd_pkg::DATE_W-1:0]  v2;
  logic [dbd_pkg::YEAR_W-1:0]  q2;
  logic [dbd_pkg::DATE_W-1:0]  t2;
  // stage 3: corrected year and remainder MMDD
  logic [dbd_pkg::YEAR_W-1:0]  y3;
  logic [dbd_pkg::REST_W-1:0]  rest3;
  // stage 4: products by the reciprocal of 100
  logic [dbd_pkg::YEAR_W-1:0]  y4;
  logic [dbd_pkg::REST_W-1:0]  rest4;
  logic [26:0]                 mp4;
  logic [26:0]                 yp4;
  logic [26:0]                 c100p4;
  logic [26:0]                 c400p4;
  // stage 5: quotients
  logic [dbd_pkg::YEAR_W-1:0]  y5;
  logic [dbd_pkg::REST_W-1:0]  rest5;
  logic [6:0]                  m5;
  logic [7:0]                  q100_5;
  logic [7:0]                  c100_5;
  logic [5:0]                  c400_5;
  // stage 6: fields, leap rule, year days
  logic [dbd_pkg::DN_W-1:0]    y365_6;
  logic [11:0]                 leaps6;
  logic                        leap6;
  logic [dbd_pkg::MONTH_W-1:0] m6;
  logic [dbd_pkg::DAY_W-1:0]   d6;
  logic                        ok6;
  // stage 7: day number
  logic [dbd_pkg::DN_W-1:0]    dn7;
  logic                        ok7;

  logic [dbd_pkg::DATE_W-1:0]  r_full;
  logic [14:0]                 r3;
  logic                        wrap3;
  logic [6:0]                  d_calc;
  logic [6:0]                  r100;
  logic                        leap_calc;
  logic [11:0]                 leaps_calc;
  logic                        ok_calc;

  // remainder after the year estimate is below twice 10000
  always_comb begin
    r_full = v2 - t2;
    r3     = r_full[14:0];
    wrap3  = (r3 >= 15'(dbd_pkg::TEN_K));
  end

  always_comb begin
    d_calc     = 7'(rest5 - 14'(14'(m5) * 14'(dbd_pkg::HUNDRED)));
    r100       = 7'(y5 - 14'(14'(q100_5) * 14'(dbd_pkg::HUNDRED)));
    // divisible by 400 iff divisible by 100 with a quotient divisible by 4
    leap_calc  = ((y5[1:0] == 2'd0) && (r100 != 7'd0)) ||
                 ((r100 == 7'd0) && (q100_5[1:0] == 2'd0));
    leaps_calc = 12'((y5 + 14'd3) >> 2) - 12'(c100_5) + 12'(c400_5);
    ok_calc    = (m5 inside {[7'd1:7'd12]}) && (d_calc inside {[7'd1:7'd31]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1     <= date;
      p1     <= PROD_W'(date) * PROD_W'(dbd_pkg::RECIP_10K);

      v2     <= v1;
      q2     <= dbd_pkg::YEAR_W'(p1 >> dbd_pkg::RECIP_10K_SHIFT);
      t2     <= dbd_pkg::DATE_W'(dbd_pkg::DATE_W'(p1 >> dbd_pkg::RECIP_10K_SHIFT) *
                                 dbd_pkg::DATE_W'(dbd_pkg::TEN_K));

      y3     <= wrap3 ? q2 + 14'd1 : q2;
      rest3  <= wrap3 ? 14'(r3 - 15'(dbd_pkg::TEN_K)) : r3[13:0];

      y4     <= y3;
      rest4  <= rest3;
      mp4    <= 27'(rest3) * 27'(dbd_pkg::RECIP_100);
      yp4    <= 27'(y3) * 27'(dbd_pkg::RECIP_100);
      c100p4 <= 27'(y3 + 14'd99) * 27'(dbd_pkg::RECIP_100);
      c400p4 <= 27'((15'(y3) + 15'd399) >> 2) * 27'(dbd_pkg::RECIP_100);

      y5     <= y4;
      rest5  <= rest4;
      m5     <= 7'(mp4 >> dbd_pkg::RECIP_100_SHIFT);
      q100_5 <= 8'(yp4 >> dbd_pkg::RECIP_100_SHIFT);
      c100_5 <= 8'(c100p4 >> dbd_pkg::RECIP_100_SHIFT);
      c400_5 <= 6'(c400p4 >> dbd_pkg::RECIP_100_SHIFT);

      y365_6 <= dbd_pkg::DN_W'(dbd_pkg::DN_W'(y5) * dbd_pkg::DN_W'(dbd_pkg::DAYS_PER_YEAR));
      leaps6 <= leaps_calc;
      leap6  <= leap_calc;
      m6     <= m5[3:0];
      d6     <= d_calc[4:0];
      ok6    <= ok_calc;

      dn7    <= y365_6 + dbd_pkg::DN_W'(leaps6)
              + dbd_pkg::DN_W'(dbd_pkg::days_before_month(leap6, m6))
              + dbd_pkg::DN_W'(d6) - 23'd1;
      ok7    <= ok6;
    end
  end

  assign result = '{ok: ok7, dn: dn7};

endmodule

FILE: sv/dbd_merge.sv
// Merge: lane difference with saturation, then a two-entry output queue.
`include "assert_macros.svh"

module dbd_merge (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  dbd_pkg::lane_out_t             lane_a,
  input  dbd_pkg::lane_out_t             lane_b,
  output logic                           en,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dbd_pkg::M_TDATA_W-1:0]  m_tdata,   // [22:0] day_difference
  output logic                           m_tuser    // [0] bad_date
);

  localparam logic signed [23:0] LIM24 = 24'(dbd_pkg::DIFF_LIMIT);
  localparam logic signed [dbd_pkg::DIFF_W-1:0] LIM = dbd_pkg::DIFF_W'(dbd_pkg::DIFF_LIMIT);

  logic signed [23:0]          diff;
  logic [dbd_pkg::DIFF_W-1:0]  new_diff;
  logic                        new_bad;

  logic                        out_valid;
  logic [dbd_pkg::DIFF_W-1:0]  out_diff;
  logic                        out_bad;
  logic                        spare_valid;
  logic [dbd_pkg::DIFF_W-1:0]  spare_diff;
  logic                        spare_bad;
  logic                        pop;

  always_comb begin
    diff    = $signed({1'b0, lane_b.dn}) - $signed({1'b0, lane_a.dn});
    new_bad = !(lane_a.ok && lane_b.ok);
    if (new_bad) begin
      new_diff = '0;
    end else if (diff > LIM24) begin
      new_diff = LIM;
    end else if (diff < -LIM24) begin
      new_diff = -LIM;
    end else begin
      new_diff = diff[dbd_pkg::DIFF_W-1:0];
    end
  end

  assign pop = out_valid && m_tready;
  // stall only with both entries full, so the pipeline never overruns the queue
  assign en  = !(out_valid && spare_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= push;
      end else begin
        out_valid   <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      if (spare_valid) begin
        out_diff   <= spare_diff;
        out_bad    <= spare_bad;
        spare_diff <= new_diff;
        spare_bad  <= new_bad;
      end else begin
        out_diff   <= new_diff;
        out_bad    <= new_bad;
      end
    end else if (push) begin
      spare_diff <= new_diff;
      spare_bad  <= new_bad;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = dbd_pkg::M_TDATA_W'(out_diff);
  assign m_tuser  = out_bad;

  `DBD_ASSERT(a_spare_behind_head, spare_valid |-> out_valid, "spare entry without head entry")
  `DBD_ASSERT(a_bad_gives_zero, (out_valid && out_bad) |-> (out_diff == '0), "bad date with nonzero difference")
  `DBD_ASSERT(a_diff_in_range, out_valid |-> (($signed(out_diff) <= LIM) && ($signed(out_diff) >= -LIM)), "difference beyond limit")
  `DBD_ASSERT_KNOWN(a_tvalid_known, out_valid, "m_tvalid unknown")

endmodule

FILE: sv/days_between_dates.sv
// Top level: signed Gregorian day count between two packed decimal dates.
//
// Each input transfer carries two dates written as the decimal number YYYYMMDD.
// Two identical lanes turn the dates into running day numbers (days since year 0,
// Gregorian leap rule, year 0 a leap year) and a merge stage subtracts them: the
// result is the days from the first date to the second, negative when the second
// is earlier, saturated to +/-3660000. A month outside 1..12 or a day outside
// 1..31 in either date sets bad_date and forces the difference to 0; a day past
// the end of its month simply rolls into the next month. Rate: one transfer per
// clock in both directions while m_tready stays high. From input transfer to
// m_tvalid a result passes the seven lane stages (reciprocal divide by 10000
// with one correction step, divides by 100, leap count, day-number sum) and the
// output register. The output side is a two-entry queue, so the input keeps
// accepting while a result waits and s_tready drops only once both queue
// entries are occupied. No configuration, no state beyond the pipeline.
module days_between_dates (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dbd_pkg::S_TDATA_W-1:0]  s_tdata,   // [26:0] first_date, [53:27] second_date
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dbd_pkg::M_TDATA_W-1:0]  m_tdata,   // [22:0] day_difference
  output logic                           m_tuser    // [0] bad_date
);

  logic                              en;
  logic [dbd_pkg::LANE_DEPTH-1:0]    vld;
  dbd_pkg::lane_out_t                lane_a;
  dbd_pkg::lane_out_t                lane_b;
  logic                              push;

  // whole pipeline moves as one while the queue has room
  assign s_tready = en;

  // valid bits alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[dbd_pkg::LANE_DEPTH-2:0], s_tvalid};
    end
  end

  assign push = en && vld[dbd_pkg::LANE_DEPTH-1];

  dbd_lane u_lane_first (
    .clk    (clk),
    .en     (en),
    .date   (s_tdata[dbd_pkg::DATE_W-1:0]),
    .result (lane_a)
  );

  dbd_lane u_lane_second (
    .clk    (clk),
    .en     (en),
    .date   (s_tdata[2*dbd_pkg::DATE_W-1:dbd_pkg::DATE_W]),
    .result (lane_b)
  );

  dbd_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .lane_a   (lane_a),
    .lane_b   (lane_b),
    .en       (en),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
